### hw/rtl/chpt_pkg.sv
// Shared types, codes and helpers for the clustered hashed page table.
// Used by every module under hw/rtl; depends on nothing.
package chpt_pkg;

    localparam int DEF_WAYS           = 4;
    localparam int DEF_MAX_SETS       = 256;
    localparam int DEF_STACK_TOP_PAGE = 524288;
    localparam int DEF_STACK_PAGES    = 18;

    localparam int SET_IDX_W = 12;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INVAL  = 1'b1;

    localparam logic [2:0] CFG_SET_COUNT   = 3'd0;
    localparam logic [2:0] CFG_FIRST_FRAME = 3'd1;
    localparam logic [2:0] CFG_SEG1_BASE   = 3'd2;
    localparam logic [2:0] CFG_SEG1_COUNT  = 3'd3;
    localparam logic [2:0] CFG_SEG2_BASE   = 3'd4;
    localparam logic [2:0] CFG_SEG2_COUNT  = 3'd5;
    localparam logic [2:0] CFG_PERM        = 3'd6;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_FILL    = 3'd1,
        ST_REPLACE = 3'd2,
        ST_FAULT   = 3'd3,
        ST_INVAL   = 3'd4,
        ST_MISS    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_CHECK,
        BS_VMOD,
        BS_DONE
    } t_back_state;

    typedef struct packed {
        logic                 op;
        logic [19:0]          vpage;
        logic [11:0]          pid;
        logic [SET_IDX_W-1:0] set_idx;
        logic                 fault;
        logic                 wr;
        logic                 ex;
    } t_job;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        lfsr_next = (s >> 1) ^ (s[0] ? LFSR_MASK : 16'd0);
    endfunction

endpackage

### hw/rtl/chpt_front.sv
// Front end: accepts requests, classifies the page segment and reduces
// the page modulo the set count one bit per cycle. Uses chpt_pkg.
module chpt_front import chpt_pkg::*; #(
    parameter int MAX_SETS       = DEF_MAX_SETS,
    parameter int STACK_TOP_PAGE = DEF_STACK_TOP_PAGE,
    parameter int STACK_PAGES    = DEF_STACK_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [19:0] i_vpage,
    input  logic [11:0] i_pid,
    input  logic [8:0]  i_set_count,
    input  logic [19:0] i_seg1_base,
    input  logic [19:0] i_seg1_count,
    input  logic [19:0] i_seg2_base,
    input  logic [19:0] i_seg2_count,
    input  logic [4:0]  i_perm,
    output t_job        o_job,
    output logic        o_job_valid,
    input  logic        i_job_ready
);

    localparam int STACK_LO = STACK_TOP_PAGE - STACK_PAGES;

    t_front_state r_state, n_state;
    t_job         r_job;
    logic [8:0]   r_div;
    logic [8:0]   r_rem;
    logic [19:0]  r_shift;
    logic [4:0]   r_cnt;

    logic        w_acc;
    logic [8:0]  w_div;
    logic [9:0]  w_rem_sh;
    logic [8:0]  w_rem_nx;
    logic        w_in1, w_in2, w_stk;
    logic [20:0] w_vp;

    assign w_acc = i_valid && o_ready;
    assign w_vp  = {1'b0, i_vpage};
    assign w_in1 = (w_vp >= {1'b0, i_seg1_base}) &&
                   (w_vp < ({1'b0, i_seg1_base} + {1'b0, i_seg1_count}));
    assign w_in2 = (w_vp >= {1'b0, i_seg2_base}) &&
                   (w_vp < ({1'b0, i_seg2_base} + {1'b0, i_seg2_count}));
    assign w_stk = (int'(i_vpage) >= STACK_LO) && (int'(i_vpage) < STACK_TOP_PAGE);

    always_comb begin
        if (i_set_count == 9'd0) begin
            w_div = 9'd1;
        end else if (32'(i_set_count) > MAX_SETS) begin
            w_div = 9'(MAX_SETS);
        end else begin
            w_div = i_set_count;
        end
    end

    assign w_rem_sh = {r_rem, r_shift[19]};
    assign w_rem_nx = (w_rem_sh >= {1'b0, r_div}) ? 9'(w_rem_sh - {1'b0, r_div})
                                                  : w_rem_sh[8:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (w_acc) n_state = FS_DIV;
            FS_DIV:  if (r_cnt == 5'd19) n_state = FS_PUSH;
            FS_PUSH: if (i_job_ready) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == FS_IDLE);
        o_job_valid = (r_state == FS_PUSH);
        o_job       = r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_job.op      <= i_opcode;
            r_job.vpage   <= i_vpage;
            r_job.pid     <= i_pid;
            r_job.set_idx <= '0;
            r_job.fault   <= 1'b0;
            r_job.wr      <= 1'b0;
            r_job.ex      <= 1'b0;
            if (i_opcode == OP_LOOKUP) begin
                priority if (w_in1) begin
                    r_job.wr <= i_perm[1];
                    r_job.ex <= i_perm[0];
                end else if (w_in2) begin
                    r_job.wr <= i_perm[4];
                    r_job.ex <= i_perm[3];
                end else if (w_stk) begin
                    r_job.wr <= 1'b1;
                end else begin
                    r_job.fault <= 1'b1;
                end
            end
            r_div   <= w_div;
            r_rem   <= '0;
            r_shift <= i_vpage;
            r_cnt   <= '0;
        end else if (r_state == FS_DIV) begin
            r_rem   <= w_rem_nx;
            r_shift <= {r_shift[18:0], 1'b0};
            r_cnt   <= r_cnt + 5'd1;
            if (r_cnt == 5'd19) begin
                r_job.set_idx <= SET_IDX_W'(w_rem_nx);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_DIV) |-> (r_rem < r_div))
        else $error("remainder not below divisor");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_PUSH) |-> (32'(r_job.set_idx) < MAX_SETS))
        else $error("set index out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_PUSH && r_job.op == OP_INVAL) |-> !r_job.fault)
        else $error("invalidate marked as fault");

endmodule

### hw/rtl/chpt_fifo.sv
// Two-entry queue of classified jobs between front and back ends.
// Uses t_job from chpt_pkg.
module chpt_fifo import chpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_data,
    input  logic i_push_valid,
    output logic o_push_ready,
    output t_job o_data,
    output logic o_pop_valid,
    input  logic i_pop_ready
);

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_data       = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop)  r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_data;
    end

endmodule

### hw/rtl/chpt_back.sv
// Back end: owns the entry memory, clears it after reset, scans a set's
// ways, picks the victim and registers the result. Uses chpt_pkg.
module chpt_back import chpt_pkg::*; #(
    parameter int WAYS     = DEF_WAYS,
    parameter int MAX_SETS = DEF_MAX_SETS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  logic [17:0] i_first_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [19:0] o_frame,
    output logic        o_writable,
    output logic        o_executable
);

    localparam int DEPTH  = MAX_SETS * WAYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam logic [21:0] RECIP_M = 22'((32'h200000 + WAYS - 1) / WAYS);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [32:0] r_mem [DEPTH];
    logic [32:0] r_rdata;
    logic [ADDR_W-1:0] r_clr;
    logic [WAY_W-1:0]  r_way, r_hit_way, r_free_way, r_rem;
    logic        r_hit, r_free;
    logic [15:0] r_lfsr, r_lsh;
    logic [15:0] r_quo;
    logic [3:0]  r_bit;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [19:0] r_frame;
    logic        r_wr, r_ex;

    logic [ADDR_W-1:0] w_base, w_raddr, w_sel_addr, w_waddr;
    logic [WAY_W-1:0]  w_sel_way;
    logic [36:0]       w_prod;
    logic [15:0]       w_rem_full;
    logic [WAY_W-1:0]  w_rem_nx;
    logic        w_last, w_match, w_fire, w_pop, w_we;
    logic [32:0] w_wdata;
    logic [2:0]  w_status;
    logic [19:0] w_frame;

    assign w_base   = ADDR_W'(r_job.set_idx[SET_W-1:0]) * ADDR_W'(WAYS);
    assign w_raddr  = w_base + ADDR_W'(r_way);
    assign w_last   = (32'(r_way) == WAYS - 1);
    assign w_match  = r_rdata[32] && (r_rdata[31:12] == r_job.vpage) &&
                      (r_rdata[11:0] == r_job.pid);
    assign w_prod     = 37'(r_lsh) * 37'(RECIP_M);
    assign w_rem_full = r_lsh - 16'(r_quo * 16'(WAYS));
    assign w_rem_nx   = WAY_W'(w_rem_full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: if (32'(r_clr) == DEPTH - 1) n_state = BS_IDLE;
            BS_IDLE:  if (i_job_valid) n_state = i_job.fault ? BS_DONE : BS_READ;
            BS_READ:  n_state = BS_CHECK;
            BS_CHECK: begin
                if (!w_last) begin
                    n_state = BS_READ;
                end else if (r_job.op == OP_LOOKUP && !r_hit && !w_match &&
                             !r_free && r_rdata[32]) begin
                    n_state = BS_VMOD;
                end else begin
                    n_state = BS_DONE;
                end
            end
            BS_VMOD:  if (r_bit == 4'd1) n_state = BS_DONE;
            BS_DONE:  if (!r_out_valid || i_ready) n_state = BS_IDLE;
            default:  n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = (r_state == BS_IDLE);
        w_pop       = o_job_ready && i_job_valid;
        w_fire      = (r_state == BS_DONE) && (!r_out_valid || i_ready);
        if (r_job.op == OP_INVAL || r_hit) begin
            w_sel_way = r_hit_way;
        end else if (r_free) begin
            w_sel_way = r_free_way;
        end else begin
            w_sel_way = r_rem;
        end
        w_sel_addr = w_base + ADDR_W'(w_sel_way);
        w_frame    = 20'(w_sel_addr) + 20'(32'(i_first_frame) * WAYS);
        priority if (r_job.op == OP_INVAL) begin
            w_status = r_hit ? ST_INVAL : ST_MISS;
        end else if (r_job.fault) begin
            w_status = ST_FAULT;
        end else if (r_hit) begin
            w_status = ST_HIT;
        end else if (r_free) begin
            w_status = ST_FILL;
        end else begin
            w_status = ST_REPLACE;
        end
        w_we    = 1'b0;
        w_waddr = w_sel_addr;
        w_wdata = '0;
        if (r_state == BS_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
        end else if (w_fire && !r_job.fault) begin
            if (r_job.op == OP_INVAL) begin
                w_we = r_hit;
            end else begin
                w_we    = !r_hit;
                w_wdata = {1'b1, r_job.vpage, r_job.pid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr       <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) r_clr <= r_clr + ADDR_W'(1);
            if (n_state == BS_VMOD && r_state == BS_CHECK) r_lfsr <= lfsr_next(r_lfsr);
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_job  <= i_job;
            r_way  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end
        if (r_state == BS_CHECK) begin
            if (w_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_way;
            end
            if (!r_rdata[32] && !r_free) begin
                r_free     <= 1'b1;
                r_free_way <= r_way;
            end
            r_way <= r_way + WAY_W'(1);
            if (n_state == BS_VMOD) begin
                r_lsh <= lfsr_next(r_lfsr);
                r_rem <= '0;
                r_bit <= '0;
            end
        end
        if (r_state == BS_VMOD) begin
            if (r_bit == 4'd0) begin
                r_quo <= w_prod[36:21];
            end else begin
                r_rem <= w_rem_nx;
            end
            r_bit <= r_bit + 4'd1;
        end
        if (w_fire) begin
            r_status <= w_status;
            r_frame  <= (r_job.fault || (r_job.op == OP_INVAL && !r_hit)) ? 20'd0 : w_frame;
            r_wr     <= (r_job.op == OP_LOOKUP) && !r_job.fault && r_job.wr;
            r_ex     <= (r_job.op == OP_LOOKUP) && !r_job.fault && r_job.ex;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_frame      = r_frame;
    assign o_writable   = r_wr;
    assign o_executable = r_ex;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_wdata[32]) |-> (r_state == BS_DONE && r_job.op == OP_LOOKUP && !r_job.fault))
        else $error("unexpected entry allocation");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FAULT) |-> (o_frame == 20'd0 && !o_writable && !o_executable))
        else $error("fault result carries data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_VMOD) |-> (!r_hit && !r_free))
        else $error("victim search with hit or free way");

endmodule

### hw/rtl/clustered_hashed_page_table_top.sv
// Clustered hashed page table top level: configuration registers and the
// front end, job queue and back end. Uses chpt_pkg, chpt_front, chpt_fifo, chpt_back.
//
// Requests (opcode, vpage, pid) enter on i_valid/o_ready; one result
// (status, frame, writable, executable) leaves per request on o_valid/i_ready.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata),
// written while the block is idle; the block itself does not enforce this.
// The front end takes a request, classifies its segment and reduces the page
// modulo the set count at one quotient bit per cycle. The back end takes the
// job, reads the set's ways one memory read at a time (a read state and then
// a check state per way; a faulting job skips the reads), computes the victim
// modulo when a set is full, and then registers the result. Front and back
// overlap through a two-entry queue, so the front end can take a new request
// while the back end still works on an earlier one.
// After reset the back end clears the MAX_SETS*WAYS entry memory, one entry
// per cycle; requests queue but get no result until the pass ends. A stalled
// receiver holds the result register; the back end then waits and the queue
// and front end fill before o_ready drops.
module clustered_hashed_page_table_top import chpt_pkg::*; #(
    parameter int WAYS           = DEF_WAYS,
    parameter int MAX_SETS       = DEF_MAX_SETS,
    parameter int STACK_TOP_PAGE = DEF_STACK_TOP_PAGE,
    parameter int STACK_PAGES    = DEF_STACK_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [19:0] i_vpage,
    input  logic [11:0] i_pid,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [19:0] o_frame,
    output logic        o_writable,
    output logic        o_executable,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_wdata
);

    logic [8:0]  r_set_count;
    logic [17:0] r_first_frame;
    logic [19:0] r_seg1_base, r_seg1_count, r_seg2_base, r_seg2_count;
    logic [4:0]  r_perm;

    t_job w_fj, w_bj;
    logic w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_count   <= 9'd256;
            r_first_frame <= '0;
            r_seg1_base   <= '0;
            r_seg1_count  <= '0;
            r_seg2_base   <= '0;
            r_seg2_count  <= '0;
            r_perm        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_COUNT:   r_set_count   <= i_cfg_wdata[8:0];
                CFG_FIRST_FRAME: r_first_frame <= i_cfg_wdata[17:0];
                CFG_SEG1_BASE:   r_seg1_base   <= i_cfg_wdata;
                CFG_SEG1_COUNT:  r_seg1_count  <= i_cfg_wdata;
                CFG_SEG2_BASE:   r_seg2_base   <= i_cfg_wdata;
                CFG_SEG2_COUNT:  r_seg2_count  <= i_cfg_wdata;
                CFG_PERM:        r_perm        <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    chpt_front #(
        .MAX_SETS(MAX_SETS),
        .STACK_TOP_PAGE(STACK_TOP_PAGE),
        .STACK_PAGES(STACK_PAGES)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_vpage(i_vpage),
        .i_pid(i_pid),
        .i_set_count(r_set_count),
        .i_seg1_base(r_seg1_base),
        .i_seg1_count(r_seg1_count),
        .i_seg2_base(r_seg2_base),
        .i_seg2_count(r_seg2_count),
        .i_perm(r_perm),
        .o_job(w_fj),
        .o_job_valid(w_fj_valid),
        .i_job_ready(w_fj_ready)
    );

    chpt_fifo u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_data(w_fj),
        .i_push_valid(w_fj_valid),
        .o_push_ready(w_fj_ready),
        .o_data(w_bj),
        .o_pop_valid(w_bj_valid),
        .i_pop_ready(w_bj_ready)
    );

    chpt_back #(
        .WAYS(WAYS),
        .MAX_SETS(MAX_SETS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job(w_bj),
        .i_job_valid(w_bj_valid),
        .o_job_ready(w_bj_ready),
        .i_first_frame(r_first_frame),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_frame(o_frame),
        .o_writable(o_writable),
        .o_executable(o_executable)
    );

endmodule

### test/tb_clustered_hashed_page_table_top.sv
// Testbench for clustered_hashed_page_table_top: directed table, then random requests, each
// result checked against the table's expected value or a behavioral page table model. Depends on chpt_pkg and the RTL.
module tb_clustered_hashed_page_table_top;
    import chpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWAYS = DEF_WAYS;
    localparam int NSETS = DEF_MAX_SETS;
    localparam int DEPTH = NWAYS * NSETS;
    localparam int RANDOM_ITEMS = 1680;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic        op;
        logic [19:0] vpage;
        logic [11:0] pid;
    } t_req;

    typedef struct packed {
        logic        known;
        t_status     status;
        logic [19:0] frame;
        logic        wr;
        logic        ex;
    } t_res;

    typedef struct packed {
        t_status     status;
        logic [19:0] frame;
        logic        wr;
        logic        ex;
    } t_exp;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, i_opcode;
    logic [19:0] i_vpage;
    logic [11:0] i_pid;
    logic        o_valid, i_ready;
    logic [2:0]  o_status;
    logic [19:0] o_frame;
    logic        o_writable, o_executable;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [19:0] i_cfg_wdata;

    clustered_hashed_page_table_top u_dut (.*);

    // page table model
    logic        pt_valid [DEPTH];
    logic [19:0] pt_page [DEPTH];
    logic [11:0] pt_pid [DEPTH];
    logic [15:0] victim_state;
    logic [8:0]  r_sets;
    logic [17:0] r_first;
    logic [19:0] r_s1b, r_s1c, r_s2b, r_s2c;
    logic [4:0]  r_perm;

    t_exp        expected_results[$];
    int          errors;
    int          cycles;
    bit          calm;
    bit          hold_off;
    bit          gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_exp translate(t_req r);
        t_exp e;
        int   sets, base, way, w;
        logic [19:0] fbase;
        e = '{ST_HIT, 20'd0, 1'b0, 1'b0};
        sets = (r_sets == 0) ? 1 : (r_sets > NSETS ? NSETS : r_sets);
        base = (r.vpage % sets) * NWAYS;
        fbase = 20'(r_first * NWAYS);
        way = -1;
        for (w = NWAYS - 1; w >= 0; w--)
            if (pt_valid[base+w] && pt_page[base+w] == r.vpage && pt_pid[base+w] == r.pid)
                way = w;
        if (r.op == OP_INVAL) begin
            if (way >= 0) begin
                pt_valid[base+way] = 1'b0;
                e.status = ST_INVAL;
                e.frame = 20'(base + way) + fbase;
            end else begin
                e.status = ST_MISS;
            end
            return e;
        end
        if (33'(r.vpage) >= 33'(r_s1b) && 33'(r.vpage) < 33'(r_s1b) + 33'(r_s1c)) begin
            e.wr = r_perm[1];
            e.ex = r_perm[0];
        end else if (33'(r.vpage) >= 33'(r_s2b) && 33'(r.vpage) < 33'(r_s2b) + 33'(r_s2c)) begin
            e.wr = r_perm[4];
            e.ex = r_perm[3];
        end else if (r.vpage >= DEF_STACK_TOP_PAGE - DEF_STACK_PAGES
                     && r.vpage < DEF_STACK_TOP_PAGE) begin
            e.wr = 1'b1;
        end else begin
            e.status = ST_FAULT;
            return e;
        end
        if (way < 0) begin
            for (w = NWAYS - 1; w >= 0; w--)
                if (!pt_valid[base+w]) way = w;
            if (way >= 0) begin
                e.status = ST_FILL;
            end else begin
                victim_state = (victim_state >> 1) ^ (victim_state[0] ? 16'hB400 : 16'h0);
                way = victim_state % NWAYS;
                e.status = ST_REPLACE;
            end
            pt_valid[base+way] = 1'b1;
            pt_page[base+way] = r.vpage;
            pt_pid[base+way] = r.pid;
        end
        e.frame = 20'(base + way) + fbase;
        return e;
    endfunction

    task automatic send_request(t_req r, t_res typed);
        t_exp e;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        e = translate(r);
        if (typed.known) e = '{typed.status, typed.frame, typed.wr, typed.ex};
        i_valid <= 1'b1;
        i_opcode <= r.op;
        i_vpage <= r.vpage;
        i_pid <= r.pid;
        expected_results.push_back(e);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SET_COUNT:   r_sets = val[8:0];
            CFG_FIRST_FRAME: r_first = val[17:0];
            CFG_SEG1_BASE:   r_s1b = val;
            CFG_SEG1_COUNT:  r_s1c = val;
            CFG_SEG2_BASE:   r_s2b = val;
            CFG_SEG2_COUNT:  r_s2c = val;
            CFG_PERM:        r_perm = val[4:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic configure(logic [8:0] sets, logic [17:0] first, logic [19:0] s1b,
                             logic [19:0] s1c, logic [19:0] s2b, logic [19:0] s2c,
                             logic [4:0] perm);
        write_reg(CFG_SET_COUNT, 20'(sets));
        write_reg(CFG_FIRST_FRAME, 20'(first));
        write_reg(CFG_SEG1_BASE, s1b);
        write_reg(CFG_SEG1_COUNT, s1c);
        write_reg(CFG_SEG2_BASE, s2b);
        write_reg(CFG_SEG2_COUNT, s2c);
        write_reg(CFG_PERM, 20'(perm));
    endtask

    function automatic logic [19:0] pick_page(int mode);
        case (mode)
            0: return r_s1b + 20'($urandom_range(0, 40));
            1: return r_s2b + 20'($urandom_range(0, 40));
            2: return 20'(DEF_STACK_TOP_PAGE - 1 - $urandom_range(0, 19));
            default: return 20'($urandom);
        endcase
    endfunction

    // response checking
    always @(posedge i_clk) begin
        t_exp e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_frame !== e.frame) begin
                    $error("frame exp %0h got %0h", e.frame, o_frame);
                    errors++;
                end
                if (o_writable !== e.wr) begin
                    $error("writable exp %0b got %0b", e.wr, o_writable);
                    errors++;
                end
                if (o_executable !== e.ex) begin
                    $error("executable exp %0b got %0b", e.ex, o_executable);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_req dir_req[20];
        t_res dir_res[20];
        t_req r;
        int   n, mode;
        logic [11:0] pidpool[4];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = 1'b0;
        i_vpage = '0;
        i_pid = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        gaps_on = 1'b1;
        for (int k = 0; k < DEPTH; k++) pt_valid[k] = 1'b0;
        victim_state = LFSR_SEED;
        r_sets = 9'd256; r_first = '0; r_s1b = '0; r_s1c = '0;
        r_s2b = '0; r_s2c = '0; r_perm = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset: every lookup outside the stack faults, stack is writable
        dir_req[0] = '{OP_LOOKUP, 20'h0, 12'h0};
        dir_res[0] = '{1'b1, ST_FAULT, 20'h0, 1'b0, 1'b0};
        dir_req[1] = '{OP_LOOKUP, 20'hFFFFF, 12'hFFF};
        dir_res[1] = '{1'b1, ST_FAULT, 20'h0, 1'b0, 1'b0};
        dir_req[2] = '{OP_INVAL, 20'hFFFFF, 12'hFFF};
        dir_res[2] = '{1'b1, ST_MISS, 20'h0, 1'b0, 1'b0};
        dir_req[3] = '{OP_LOOKUP, 20'h7FFFF, 12'hFFF};
        dir_res[3] = '{1'b1, ST_FILL, 20'h3FC, 1'b1, 1'b0};
        dir_req[4] = '{OP_LOOKUP, 20'h7FFFF, 12'hFFF};
        dir_res[4] = '{1'b1, ST_HIT, 20'h3FC, 1'b1, 1'b0};
        dir_req[5] = '{OP_LOOKUP, 20'h7FFED, 12'h0};
        dir_res[5] = '{1'b1, ST_FAULT, 20'h0, 1'b0, 1'b0};
        dir_req[6] = '{OP_LOOKUP, 20'h7FFEE, 12'h0};
        dir_res[6] = '{1'b0, ST_HIT, 20'h0, 1'b0, 1'b0};
        dir_req[7] = '{OP_LOOKUP, 20'h80000, 12'h0};
        dir_res[7] = '{1'b1, ST_FAULT, 20'h0, 1'b0, 1'b0};
        dir_req[8] = '{OP_INVAL, 20'h7FFFF, 12'hFFF};
        dir_res[8] = '{1'b1, ST_INVAL, 20'h3FC, 1'b0, 1'b0};
        dir_req[9] = '{OP_INVAL, 20'h7FFFF, 12'hFFF};
        dir_res[9] = '{1'b1, ST_MISS, 20'h0, 1'b0, 1'b0};
        for (int k = 0; k < 10; k++) send_request(dir_req[k], dir_res[k]);
        drain();

        // set count zero, taken as one: every page in one set, forcing replacement
        configure(9'd0, 18'h3FFFF, 20'h0, 20'hFFFFF, 20'hFFFF0, 20'hFFFFF, 5'b11011);
        for (int k = 0; k < 10; k++) begin
            dir_req[k] = '{OP_LOOKUP, 20'(k * 7), 12'(k)};
            dir_res[k] = '{1'b0, ST_HIT, 20'h0, 1'b0, 1'b0};
        end
        dir_req[9] = '{OP_LOOKUP, 20'hFFFFF, 12'h5};
        for (int k = 0; k < 10; k++) send_request(dir_req[k], dir_res[k]);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(9'd256, 18'd0, 20'h00100, 20'd64, 20'h40000, 20'd64, 5'b10001);
                1: configure(9'd3, 18'd5, 20'h12345, 20'd30, 20'h54321, 20'd30, 5'b01010);
                2: configure(9'h1FF, 18'h20000, 20'hFFFE0, 20'hFFFFF, 20'h0, 20'd40, 5'b11111);
                3: configure(9'd1, 18'd1, 20'h00010, 20'd0, 20'h00020, 20'd50, 5'b00000);
                4: configure(9'(1 + $urandom_range(0, 255)), 18'($urandom),
                             20'($urandom), 20'($urandom_range(1, 60)),
                             20'($urandom), 20'($urandom_range(1, 60)), 5'($urandom));
                default: configure(9'd2, 18'd7, 20'h00200, 20'd16, 20'h00300, 20'd16,
                                   5'($urandom));
            endcase
            for (int k = 0; k < 4; k++) pidpool[k] = 12'($urandom);
            if (phase == 5) begin
                calm = 1'b1;
                gaps_on = 1'b0;
            end
            n = RANDOM_ITEMS / 6;
            for (int k = 0; k < n; k++) begin
                if (phase == 1 && k == 50) hold_off = 1'b1;
                if (phase == 2 && k == 100) begin
                    while (expected_results.size() != 0) @(negedge i_clk);
                end
                mode = $urandom_range(0, 9);
                r.op = ($urandom_range(0, 3) == 0) ? OP_INVAL : OP_LOOKUP;
                r.vpage = pick_page(mode < 4 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3);
                r.pid = ($urandom_range(0, 7) == 0) ? 12'($urandom) : pidpool[$urandom_range(0, 3)];
                send_request(r, '0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/chpt_pkg.sv
hw/rtl/chpt_front.sv
hw/rtl/chpt_fifo.sv
hw/rtl/chpt_back.sv
hw/rtl/clustered_hashed_page_table_top.sv
test/tb_clustered_hashed_page_table_top.sv
